// ===== rtl/lru_page_replacement_unit_defines.svh =====
// assertion macros for the lru page replacement unit
// no dependencies; included by the top level
`ifndef LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define LRU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lru assertion failed");

// antecedent implies consequent in the next cycle
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lru assertion failed");

`else

`define LRU_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LRU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/lru_pkg.sv =====
// shared constants and types of the lru page replacement unit
// no dependencies
package lru_pkg;

	localparam int FRAMES_DEF    = 8;
	localparam int PAGE_BITS_DEF = 16;
	localparam int FRAME_SLOT_W  = 3;
	localparam int CFG_W         = 4;
	localparam int FAULT_W       = 32;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 4'd8;

	// what the lookup decided for one reference
	typedef struct packed {
		logic hit;    // page resident in an active frame
		logic fill;   // miss, loaded into an empty frame
		logic evict;  // miss, replaced the least recently used frame
	} lookup_t;

endpackage

// ===== rtl/lru_page_replacement_unit.sv =====
// lru page replacement unit: top level with input and result registers
// depends on lru_pkg, lru_lookup, lru_frames and lru_page_replacement_unit_defines.svh
//
// usage
//   request channel: page_number with req_valid / req_stall; one page reference
//   per transaction. response channel: hit, frame_slot, evicted_valid,
//   evicted_page and fault_total with rsp_valid / rsp_stall.
//   cfg_we / cfg_wdata write frames_in_use (0 acts as 1, above FRAMES as FRAMES);
//   write it only while no reference is in flight.
// pipeline and throughput
//   a reference accepted into the input register is looked up from there, and
//   its result is loaded into the result register once that register is free,
//   which raises rsp_valid. one transaction per cycle sustained while rsp_stall is
//   low: the frame search, rank update and fault count all commit as a result is loaded.
// reset
//   arst_n clears all frames to empty, ranks and fault count to zero and sets
//   frames_in_use to 8; both channels come up empty.
// stall
//   while rsp_stall holds a result, the input register still takes one more
//   transaction; req_stall rises only when that register is full and blocked.
`include "lru_page_replacement_unit_defines.svh"

module lru_page_replacement_unit #(
	parameter int FRAMES    = lru_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_we,
	input  logic [lru_pkg::CFG_W-1:0]           cfg_wdata,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [PAGE_BITS-1:0]                page_number,
	// response channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                hit,
	output logic [lru_pkg::FRAME_SLOT_W-1:0]    frame_slot,
	output logic                                evicted_valid,
	output logic [PAGE_BITS-1:0]                evicted_page,
	output logic [lru_pkg::FAULT_W-1:0]         fault_total
);

	localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int EXT_W  = (SLOT_W > lru_pkg::FRAME_SLOT_W) ? SLOT_W : lru_pkg::FRAME_SLOT_W;

	logic [lru_pkg::CFG_W-1:0]        frames_in_use_q;
	logic [lru_pkg::FAULT_W-1:0]      fault_cnt_q;

	logic                             valid_s1;
	logic [PAGE_BITS-1:0]             page_s1;

	logic                             valid_s2;
	logic                             hit_s2;
	logic [lru_pkg::FRAME_SLOT_W-1:0] slot_s2;
	logic                             evicted_valid_s2;
	logic [PAGE_BITS-1:0]             evicted_page_s2;

	logic                             req_accept;
	logic                             rsp_free;
	logic                             update;

	lru_pkg::lookup_t                 lookup;
	logic [SLOT_W-1:0]                slot;
	logic [EXT_W-1:0]                 slot_ext;
	logic [PAGE_BITS-1:0]             victim_page;

	logic [PAGE_BITS-1:0]             frame_page  [FRAMES];
	logic [FRAMES-1:0]                frame_valid;
	logic [SLOT_W-1:0]                frame_rank  [FRAMES];

	// handshake: result register frees when empty or being taken
	assign rsp_free   = !valid_s2 || !rsp_stall;
	assign req_stall  = valid_s1 && !rsp_free;
	assign req_accept = req_valid && !req_stall;
	// the reference in the input register commits its state change now
	assign update     = valid_s1 && rsp_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= lru_pkg::FRAMES_IN_USE_RST;
		end else if (cfg_we) begin
			frames_in_use_q <= cfg_wdata;
		end
	end

	// input register: filled on acceptance, emptied when its reference commits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_accept || update) begin
			valid_s1 <= req_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			page_s1 <= page_number;
		end
	end

	lru_lookup #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.SLOT_W    (SLOT_W)
	) u_lookup (
		.frames_in_use (frames_in_use_q),
		.page          (page_s1),
		.frame_page    (frame_page),
		.frame_valid   (frame_valid),
		.frame_rank    (frame_rank),
		.lookup        (lookup),
		.slot          (slot),
		.evicted_page  (victim_page)
	);

	lru_frames #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.SLOT_W    (SLOT_W)
	) u_frames (
		.clk         (clk),
		.arst_n      (arst_n),
		.update      (update),
		.lookup      (lookup),
		.slot        (slot),
		.page        (page_s1),
		.frame_page  (frame_page),
		.frame_valid (frame_valid),
		.frame_rank  (frame_rank)
	);

	// saturating fault count; it only moves when a result is loaded, so it
	// also serves as the fault_total of the result being held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_cnt_q <= '0;
		end else if (update && !lookup.hit && (fault_cnt_q != '1)) begin
			fault_cnt_q <= fault_cnt_q + lru_pkg::FAULT_W'(1);
		end
	end

	assign slot_ext = EXT_W'(slot);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rsp_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			hit_s2           <= lookup.hit;
			slot_s2          <= slot_ext[lru_pkg::FRAME_SLOT_W-1:0];
			evicted_valid_s2 <= lookup.evict;
			evicted_page_s2  <= victim_page;
		end
	end

	assign rsp_valid     = valid_s2;
	assign hit           = hit_s2;
	assign frame_slot    = slot_s2;
	assign evicted_valid = evicted_valid_s2;
	assign evicted_page  = evicted_page_s2;
	assign fault_total   = fault_cnt_q;

	// a hit never replaces a page
	`LRU_ASSERT_NOW(a_hit_no_evict, clk, arst_n, valid_s2 && hit_s2, !evicted_valid_s2)
	// every reported miss has been counted
	`LRU_ASSERT_NOW(a_miss_counted, clk, arst_n, valid_s2 && !hit_s2, fault_cnt_q != '0)
	// frames never empty again once filled
	`LRU_ASSERT_NEXT(a_valid_grow, clk, arst_n, 1'b1,
		($past(frame_valid) & ~frame_valid) == '0)
	// a hit leaves the fault count alone
	`LRU_ASSERT_NEXT(a_hit_no_fault, clk, arst_n, update && lookup.hit,
		fault_cnt_q == $past(fault_cnt_q))

endmodule

// ===== rtl/lru_lookup.sv =====
// frame search: hit match, lowest empty frame, lru victim and slot choice
// depends on lru_pkg
module lru_lookup #(
	parameter int FRAMES    = lru_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
	parameter int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic [lru_pkg::CFG_W-1:0] frames_in_use,
	input  logic [PAGE_BITS-1:0]      page,
	input  logic [PAGE_BITS-1:0]      frame_page [FRAMES],
	input  logic [FRAMES-1:0]         frame_valid,
	input  logic [SLOT_W-1:0]         frame_rank [FRAMES],
	output lru_pkg::lookup_t          lookup,
	output logic [SLOT_W-1:0]         slot,
	output logic [PAGE_BITS-1:0]      evicted_page
);

	localparam int AW = 8;

	logic [FRAMES-1:0] active;
	logic [FRAMES-1:0] hit_vec;
	logic [FRAMES-1:0] empty_vec;
	logic [SLOT_W-1:0] hit_slot;
	logic [SLOT_W-1:0] empty_slot;
	logic [SLOT_W-1:0] victim_slot;
	logic [SLOT_W-1:0] victim_rank;

	// frame 0 always takes part; a count above FRAMES covers all frames
	always_comb begin
		for (int i = 0; i < FRAMES; i++) begin
			active[i]    = (i == 0) || (AW'(frames_in_use) > AW'(i));
			hit_vec[i]   = active[i] && frame_valid[i] && (frame_page[i] == page);
			empty_vec[i] = active[i] && !frame_valid[i];
		end
	end

	// lowest index wins
	always_comb begin
		hit_slot   = '0;
		empty_slot = '0;
		for (int i = FRAMES - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_slot = SLOT_W'(i);
			end
			if (empty_vec[i]) begin
				empty_slot = SLOT_W'(i);
			end
		end
	end

	// oldest active frame, ties to the lower index
	always_comb begin
		victim_slot = '0;
		victim_rank = frame_rank[0];
		for (int i = 1; i < FRAMES; i++) begin
			if (active[i] && (frame_rank[i] > victim_rank)) begin
				victim_rank = frame_rank[i];
				victim_slot = SLOT_W'(i);
			end
		end
	end

	always_comb begin
		lookup.hit   = |hit_vec;
		lookup.fill  = !(|hit_vec) && (|empty_vec);
		lookup.evict = !(|hit_vec) && !(|empty_vec);
		priority if (lookup.hit) begin
			slot = hit_slot;
		end else if (lookup.fill) begin
			slot = empty_slot;
		end else begin
			slot = victim_slot;
		end
		evicted_page = lookup.evict ? frame_page[victim_slot] : '0;
	end

endmodule

// ===== rtl/lru_frames.sv =====
// frame storage: page numbers, valid bits and recency ranks with their update
// depends on lru_pkg
module lru_frames #(
	parameter int FRAMES    = lru_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lru_pkg::PAGE_BITS_DEF,
	parameter int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  update,
	input  lru_pkg::lookup_t      lookup,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [PAGE_BITS-1:0]  page,
	output logic [PAGE_BITS-1:0]  frame_page [FRAMES],
	output logic [FRAMES-1:0]     frame_valid,
	output logic [SLOT_W-1:0]     frame_rank [FRAMES]
);

	localparam logic [SLOT_W-1:0] RANK_MAX = SLOT_W'(FRAMES - 1);

	logic [PAGE_BITS-1:0] page_q  [FRAMES];
	logic [FRAMES-1:0]    valid_q;
	logic [SLOT_W-1:0]    rank_q  [FRAMES];
	logic [SLOT_W-1:0]    rank_d  [FRAMES];
	logic [SLOT_W-1:0]    rank_sel;

	// fill ages every valid frame (saturating); a touch ages frames younger than the slot
	always_comb begin
		rank_sel = rank_q[slot];
		for (int i = 0; i < FRAMES; i++) begin
			rank_d[i] = rank_q[i];
			if (lookup.fill) begin
				if (valid_q[i] && (rank_q[i] < RANK_MAX)) begin
					rank_d[i] = rank_q[i] + SLOT_W'(1);
				end
			end else if (valid_q[i] && (rank_q[i] < rank_sel)) begin
				rank_d[i] = rank_q[i] + SLOT_W'(1);
			end
			if (SLOT_W'(i) == slot) begin
				rank_d[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (update) begin
			rank_q <= rank_d;
			valid_q[slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (update && !lookup.hit) begin
			page_q[slot] <= page;
		end
	end

	assign frame_page  = page_q;
	assign frame_valid = valid_q;
	assign frame_rank  = rank_q;

endmodule

// ===== tb/tb_lru_page_replacement_unit.sv =====
// testbench for lru_page_replacement_unit: directed rows, then paced random reference streams
// depends on lru_pkg and the rtl of lru_page_replacement_unit; results checked against an
// in-bench lru predictor
module tb_lru_page_replacement_unit;

	localparam int NFRAMES       = lru_pkg::FRAMES_DEF;
	localparam int PBITS         = lru_pkg::PAGE_BITS_DEF;
	localparam int SW            = lru_pkg::FRAME_SLOT_W;
	localparam int FW            = lru_pkg::FAULT_W;
	localparam int CW            = lru_pkg::CFG_W;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 200;
	localparam int REPORT_LIMIT  = 10;
	localparam int DIRECTED_ROWS = 18;

	// one result transaction, field for field as on the response ports
	typedef struct packed {
		logic             hit;
		logic [SW-1:0]    slot;
		logic             ev_valid;
		logic [PBITS-1:0] ev_page;
		logic [FW-1:0]    faults;
	} page_result_t;

	// one directed row: optional frame count change, then one reference
	typedef struct packed {
		logic             set_cfg;
		logic [CW-1:0]    cfg;
		logic [PBITS-1:0] page;
		logic             typed;
		page_result_t     want;
	} ref_row_t;

	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SENDER_IDLE,
		PACE_RECEIVER_STALL,
		PACE_BOTH
	} pace_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CW-1:0]           cfg_wdata = '0;
	logic                    req_valid = 1'b0;
	logic                    req_stall;
	logic [PBITS-1:0]        page_number = '0;
	logic                    rsp_valid;
	logic                    rsp_stall = 1'b0;
	logic                    hit;
	logic [SW-1:0]           frame_slot;
	logic                    evicted_valid;
	logic [PBITS-1:0]        evicted_page;
	logic [FW-1:0]           fault_total;

	lru_page_replacement_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.page_number  (page_number),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.hit          (hit),
		.frame_slot   (frame_slot),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_total  (fault_total)
	);

	// predictor state: frame contents, recency ages and the frame count setting
	logic [PBITS-1:0]        res_page  [NFRAMES];
	logic                    res_valid [NFRAMES];
	logic [SW-1:0]           age_rank  [NFRAMES];
	logic [FW-1:0]           fault_count;
	logic [CW-1:0]           frames_setting;

	page_result_t pending_results [$];
	int           mismatches = 0;
	int           sender_idle_pct = 0;
	int           receiver_stall_pct = 0;

	// directed rows; typed expectations only where they are obvious from the rules
	ref_row_t directed_rows [DIRECTED_ROWS] = '{
		// after reset, all eight frames active and empty
		'{1'b0, 4'd0,  16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1}},
		'{1'b0, 4'd0,  16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2}},
		'{1'b0, 4'd0,  16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2}},
		// one active frame: page held only in frame 1 misses and evicts frame 0
		'{1'b1, 4'd1,  16'hFFFF, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 32'd3}},
		'{1'b0, 4'd0,  16'h0000, 1'b0, '0},
		// zero frames acts as one
		'{1'b1, 4'd0,  16'h0000, 1'b0, '0},
		'{1'b0, 4'd0,  16'h00FF, 1'b0, '0},
		// three frames: hit in frame 1, fill frame 2, then evict
		'{1'b1, 4'd3,  16'hFFFF, 1'b0, '0},
		'{1'b0, 4'd0,  16'h8000, 1'b0, '0},
		'{1'b0, 4'd0,  16'h0001, 1'b0, '0},
		// fifteen acts as eight: fill the rest, then evict the oldest
		'{1'b1, 4'd15, 16'h0002, 1'b0, '0},
		'{1'b0, 4'd0,  16'h0003, 1'b0, '0},
		'{1'b0, 4'd0,  16'h0004, 1'b0, '0},
		'{1'b0, 4'd0,  16'h0005, 1'b0, '0},
		'{1'b0, 4'd0,  16'h0006, 1'b0, '0},
		'{1'b0, 4'd0,  16'h7FFF, 1'b0, '0},
		'{1'b0, 4'd0,  16'h0002, 1'b0, '0},
		'{1'b1, 4'd8,  16'h00FF, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#12_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// frame s becomes most recent; valid frames younger than it age by one
	function automatic void make_recent(input int s);
		logic [SW-1:0] old_age;
		old_age = age_rank[s];
		for (int i = 0; i < NFRAMES; i++)
			if (i != s && res_valid[i] && age_rank[i] < old_age)
				age_rank[i] = age_rank[i] + 1'b1;
		age_rank[s] = '0;
	endfunction

	// lru lookup and replacement for one reference, updating the predictor state
	function automatic page_result_t predict_reference(input logic [PBITS-1:0] pg);
		page_result_t  r;
		int            active;
		int            s;
		logic          found;
		logic [SW-1:0] oldest;
		r = '0;
		s = 0;
		found = 1'b0;
		active = (frames_setting == 0) ? 1 :
			(frames_setting > NFRAMES ? NFRAMES : frames_setting);
		for (int i = 0; i < active; i++)
			if (!found && res_valid[i] && res_page[i] == pg) begin
				found = 1'b1;
				s = i;
			end
		if (found) begin
			r.hit = 1'b1;
			make_recent(s);
		end else begin
			for (int i = 0; i < active; i++)
				if (!found && !res_valid[i]) begin
					found = 1'b1;
					s = i;
				end
			if (found) begin
				// empty frame: every valid frame ages, capped at the oldest rank
				for (int i = 0; i < NFRAMES; i++)
					if (res_valid[i] && age_rank[i] < NFRAMES - 1)
						age_rank[i] = age_rank[i] + 1'b1;
				age_rank[s] = '0;
				res_valid[s] = 1'b1;
				res_page[s] = pg;
			end else begin
				// victim: largest age, lowest frame on a tie
				oldest = age_rank[0];
				for (int i = 1; i < active; i++)
					if (age_rank[i] > oldest) begin
						oldest = age_rank[i];
						s = i;
					end
				r.ev_valid = 1'b1;
				r.ev_page = res_page[s];
				res_page[s] = pg;
				make_recent(s);
			end
			if (fault_count != '1)
				fault_count = fault_count + 1'b1;
		end
		r.slot = SW'(s);
		r.faults = fault_count;
		return r;
	endfunction

	// one request transaction, with a random gap first; prediction at acceptance
	task automatic send_page(input logic [PBITS-1:0] pg, input logic use_want,
			input page_result_t want);
		page_result_t r;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		page_number <= pg;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		r = predict_reference(pg);
		pending_results.push_back(use_want ? want : r);
	endtask

	// stop sending and wait until every result is back
	task automatic drain_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// frame count change, only with the unit idle
	task automatic write_frames(input logic [CW-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		frames_setting = v;
	endtask

	task automatic set_pace(input pace_t p);
		case (p)
			PACE_FULL: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 0;
			end
			PACE_SENDER_IDLE: begin
				sender_idle_pct = 76;
				receiver_stall_pct = 0;
			end
			PACE_RECEIVER_STALL: begin
				sender_idle_pct = 0;
				receiver_stall_pct = 76;
			end
			default: begin
				sender_idle_pct = 22;
				receiver_stall_pct = 22;
			end
		endcase
	endtask

	// receiver stall, redrawn every cycle
	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

	// response checker: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		page_result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected transaction: hit=%0d slot=%0d ev=%0d page=%h faults=%0d",
						hit, frame_slot, evicted_valid, evicted_page, fault_total);
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit || frame_slot !== want.slot ||
						evicted_valid !== want.ev_valid || evicted_page !== want.ev_page ||
						fault_total !== want.faults) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("mismatch: want hit=%0d slot=%0d ev=%0d page=%h faults=%0d",
							want.hit, want.slot, want.ev_valid, want.ev_page, want.faults);
						$display("          got  hit=%0d slot=%0d ev=%0d page=%h faults=%0d",
							hit, frame_slot, evicted_valid, evicted_page, fault_total);
					end
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [PBITS-1:0] pool [16];
		int               pool_size;
		logic [PBITS-1:0] pg;
		logic [CW-1:0]    phase_cfg [RANDOM_PHASES];

		phase_cfg = '{4'd15, 4'd0, 4'd1, 4'd8, 4'd3, 4'd2, 4'd5, 4'd8};
		for (int i = 0; i < NFRAMES; i++) begin
			res_page[i] = '0;
			res_valid[i] = 1'b0;
			age_rank[i] = '0;
		end
		fault_count = '0;
		frames_setting = lru_pkg::FRAMES_IN_USE_RST;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at full rate
		set_pace(PACE_FULL);
		for (int n = 0; n < DIRECTED_ROWS; n++) begin
			if (directed_rows[n].set_cfg)
				write_frames(directed_rows[n].cfg);
			send_page(directed_rows[n].page, directed_rows[n].typed, directed_rows[n].want);
		end

		// random part: references mostly drawn from a small working set so hits are common
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_frames(ph >= 6 ? CW'($urandom_range(15)) : phase_cfg[ph]);
			set_pace(pace_t'(ph % 4));
			pool_size = $urandom_range(16, 2);
			for (int i = 0; i < 16; i++)
				pool[i] = PBITS'($urandom);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// sender holds off mid-phase until the pipe is empty
				if (n == PHASE_ITEMS / 2)
					drain_results();
				if ($urandom_range(99) < 80)
					pg = pool[$urandom_range(pool_size - 1)];
				else
					pg = PBITS'($urandom);
				send_page(pg, 1'b0, '0);
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
